[rtl/assert_macros.svh]
// Assertion macros shared by the page header validator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define PHV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define PHV_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `PHV_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

[rtl/phv_pkg.sv]
// Package for the page header validator: item types, page record, constants,
// status codes and the byte-wise CRC-32 update. No dependencies.
package phv_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int POS_W      = $clog2(PAGE_BYTES);
    localparam int REC_DEPTH  = 2;
    localparam int RES_DEPTH  = 2;

    localparam logic [31:0] CRC_POLY     = 32'hedb88320;
    localparam logic [31:0] CRC_ONES     = 32'hffffffff;
    localparam logic [31:0] PAGE_MAGIC   = 32'h534c5441;
    localparam logic [15:0] PAGE_VERSION = 16'd1;
    localparam logic [15:0] TYPE_MIN     = 16'd1;
    localparam logic [15:0] TYPE_MAX     = 16'd4;

    // Header byte offsets
    localparam int OFS_VERSION  = 4;
    localparam int OFS_TYPE     = 6;
    localparam int OFS_ID       = 8;
    localparam int OFS_ID_END   = 15;
    localparam int OFS_CSUM     = 24;
    localparam int OFS_CSUM_END = 27;
    localparam int OFS_SLOTS    = 28;
    localparam int OFS_LOWER    = 30;
    localparam int OFS_UPPER    = 32;
    localparam int OFS_FLAGS    = 34;
    localparam int OFS_RESV     = 44;
    localparam int OFS_RESV_END = 63;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_CRC    = 3'd1;
    localparam logic [2:0] ST_IDENT  = 3'd2;
    localparam logic [2:0] ST_TYPE   = 3'd3;
    localparam logic [2:0] ST_META   = 3'd4;
    localparam logic [2:0] ST_RESV   = 3'd5;
    localparam logic [2:0] ST_BOUNDS = 3'd6;

    // Configuration register indexes
    localparam logic REG_HEADER_BYTES = 1'b0;
    localparam logic REG_META_TYPE    = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [63:0] expected_page_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] computed_crc;
        logic [15:0] page_type;
        logic [63:0] page_id;
    } out_item_t;

    // Everything the checker needs about one finished page.
    typedef struct packed {
        logic [31:0] crc;
        logic [31:0] stored_crc;
        logic [63:0] expected_id;
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] page_type;
        logic [63:0] page_id;
        logic [15:0] slot_count;
        logic [15:0] lower_bound;
        logic [15:0] upper_bound;
        logic [15:0] flags;
        logic        resv_nonzero;
        logic [15:0] header_bytes;
        logic [2:0]  meta_code;
    } page_rec_t;

    function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c ^ (crc >> 8);
    endfunction

endpackage

[rtl/phv_front.sv]
// Front end of the page header validator: byte intake, CRC update, header
// field capture and page record hand-off. Uses phv_pkg.
module phv_front
    import phv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    page_byte,
    input  logic [15:0] header_bytes,
    input  logic [2:0]  meta_code,
    output logic        rec_push,
    input  logic        rec_full,
    output page_rec_t   rec_data
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAGE_BYTES - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic             resv_reg, resv_next;
    logic [31:0]      stored_crc_reg;
    logic [63:0]      exp_id_reg;
    logic [31:0]      magic_reg;
    logic [15:0]      version_reg;
    logic [15:0]      type_reg;
    logic [63:0]      id_reg;
    logic [15:0]      slots_reg;
    logic [15:0]      lower_reg;
    logic [15:0]      upper_reg;
    logic [15:0]      flags_reg;

    logic       accept;
    logic       last;
    logic       in_csum;
    logic       in_resv;
    logic [7:0] b;

    assign b       = page_byte.data_byte;
    assign last    = (pos_reg == LAST_POS);
    assign full    = last && rec_full;
    assign accept  = push && !full;
    assign in_csum = (pos_reg >= POS_W'(OFS_CSUM)) && (pos_reg <= POS_W'(OFS_CSUM_END));
    assign in_resv = (pos_reg >= POS_W'(OFS_RESV)) && (pos_reg <= POS_W'(OFS_RESV_END));

    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        resv_next = resv_reg;
        if (accept)
        begin
            crc_next  = crc32_byte(crc_reg, in_csum ? 8'h00 : b);
            resv_next = resv_reg || (in_resv && (b != 8'h00));
            pos_next  = last ? '0 : pos_reg + POS_W'(1);
            if (last)
            begin
                // Drop per-page state once the record leaves
                crc_next  = CRC_ONES;
                resv_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            crc_reg  <= CRC_ONES;
            resv_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            resv_reg <= resv_next;
        end
    end

    // Field capture: every field is fully rewritten before each page ends
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (pos_reg == '0)
                exp_id_reg <= page_byte.expected_page_id;
            if (in_csum)
                stored_crc_reg[8*pos_reg[1:0] +: 8] <= b;
            if (pos_reg < POS_W'(OFS_VERSION))
                magic_reg[8*pos_reg[1:0] +: 8] <= b;
            if (pos_reg == POS_W'(OFS_VERSION))     version_reg[7:0]  <= b;
            if (pos_reg == POS_W'(OFS_VERSION + 1)) version_reg[15:8] <= b;
            if (pos_reg == POS_W'(OFS_TYPE))        type_reg[7:0]     <= b;
            if (pos_reg == POS_W'(OFS_TYPE + 1))    type_reg[15:8]    <= b;
            if ((pos_reg >= POS_W'(OFS_ID)) && (pos_reg <= POS_W'(OFS_ID_END)))
                id_reg[8*pos_reg[2:0] +: 8] <= b;
            if (pos_reg == POS_W'(OFS_SLOTS))       slots_reg[7:0]    <= b;
            if (pos_reg == POS_W'(OFS_SLOTS + 1))   slots_reg[15:8]   <= b;
            if (pos_reg == POS_W'(OFS_LOWER))       lower_reg[7:0]    <= b;
            if (pos_reg == POS_W'(OFS_LOWER + 1))   lower_reg[15:8]   <= b;
            if (pos_reg == POS_W'(OFS_UPPER))       upper_reg[7:0]    <= b;
            if (pos_reg == POS_W'(OFS_UPPER + 1))   upper_reg[15:8]   <= b;
            if (pos_reg == POS_W'(OFS_FLAGS))       flags_reg[7:0]    <= b;
            if (pos_reg == POS_W'(OFS_FLAGS + 1))   flags_reg[15:8]   <= b;
        end
    end

    // The last byte only adds to the CRC, so the record takes the updated CRC
    assign rec_push = accept && last;

    always_comb
    begin
        rec_data.crc          = ~crc32_byte(crc_reg, b);
        rec_data.stored_crc   = stored_crc_reg;
        rec_data.expected_id  = exp_id_reg;
        rec_data.magic        = magic_reg;
        rec_data.version      = version_reg;
        rec_data.page_type    = type_reg;
        rec_data.page_id      = id_reg;
        rec_data.slot_count   = slots_reg;
        rec_data.lower_bound  = lower_reg;
        rec_data.upper_bound  = upper_reg;
        rec_data.flags        = flags_reg;
        rec_data.resv_nonzero = resv_reg;
        rec_data.header_bytes = header_bytes;
        rec_data.meta_code    = meta_code;
    end

endmodule

[rtl/phv_rec_queue.sv]
// Short queue of finished page records between front and back end.
// Uses phv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module phv_rec_queue
    import phv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  page_rec_t rec_in,
    output logic      full,
    input  logic      pop,
    output page_rec_t rec_out,
    output logic      empty
);

    localparam int PTR_W = $clog2(REC_DEPTH);
    localparam int CNT_W = $clog2(REC_DEPTH + 1);

    page_rec_t         entries_reg [REC_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(REC_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rec_out = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(REC_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(REC_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= rec_in;
    end

    `PHV_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(REC_DEPTH), "record count over depth")
    `PHV_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "record pushed into full queue")
    `PHV_ASSERT(a_pop_drains, clk, rst_n, (do_pop && !do_push) |=> (count_reg == $past(count_reg) - CNT_W'(1)), "pop did not drain one record")

endmodule

[rtl/phv_back.sv]
// Back end of the page header validator: runs the header checks on one page
// record and holds results in a small output queue. Uses phv_pkg.
module phv_back
    import phv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rec_empty,
    output logic      rec_pop,
    input  page_rec_t rec_data,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    out_item_t        res_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             res_full, do_write, do_read;

    // header_bytes + 4 * slot_count reaches 19 bits; keep the full sum
    logic [18:0] lower_exp;
    logic        bounds_bad, meta_id, meta_type, ident_bad, type_bad;
    logic [2:0]  status;
    out_item_t   res_in;

    // Checks, first failure wins
    always_comb
    begin
        lower_exp  = {3'b000, rec_data.header_bytes} + {1'b0, rec_data.slot_count, 2'b00};
        bounds_bad = ({3'b000, rec_data.lower_bound} != lower_exp)
                  || (rec_data.lower_bound > rec_data.upper_bound)
                  || ({1'b0, rec_data.upper_bound} > 17'(PAGE_BYTES));
        meta_id    = (rec_data.page_id == 64'd0);
        meta_type  = (rec_data.page_type == {13'd0, rec_data.meta_code});
        ident_bad  = (rec_data.magic != PAGE_MAGIC) || (rec_data.version != PAGE_VERSION)
                  || (rec_data.page_id != rec_data.expected_id);
        type_bad   = (rec_data.page_type < TYPE_MIN) || (rec_data.page_type > TYPE_MAX)
                  || (rec_data.flags != 16'd0);
        if (rec_data.crc != rec_data.stored_crc)
            status = ST_CRC;
        else if (ident_bad)
            status = ST_IDENT;
        else if (type_bad)
            status = ST_TYPE;
        else if (meta_id != meta_type)
            status = ST_META;
        else if (rec_data.resv_nonzero)
            status = ST_RESV;
        else if (bounds_bad)
            status = ST_BOUNDS;
        else
            status = ST_OK;

        res_in.status       = status;
        res_in.computed_crc = rec_data.crc;
        res_in.page_type    = rec_data.page_type;
        res_in.page_id      = rec_data.page_id;
    end

    assign res_full = (count_reg == CNT_W'(RES_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_write = !rec_empty && !res_full;
    assign do_read  = pop && !empty;
    assign rec_pop  = do_write;
    assign result   = res_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_write)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_read)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_write && !do_read)
            count_next = count_reg + CNT_W'(1);
        else if (do_read && !do_write)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            res_reg[wr_ptr_reg] <= res_in;
    end

endmodule

[rtl/page_header_validator_top.sv]
// Top level of the page header validator: configuration registers and the
// front end, record queue and back end. Uses phv_pkg.
//
// The block takes one page byte per cycle while full is low, offset zero
// first, and after the last byte of a page (PAGE_BYTES bytes) delivers one
// result item with the status of the first failed header check, the CRC-32
// of the page with the checksum bytes 24 to 27 taken as zero, the page type
// and the page id. Throughput is one byte per clock while full is low, set
// by the byte-wide CRC update in the front end. The page record enters the
// record queue at the edge that accepts the last byte, and the checker then
// writes the result into the output queue once that queue has room. Full
// rises only on the last byte of a page while two finished pages still wait
// for the checker; the output queue holds two results, so a stalled reader
// blocks input only after several pages. expected_page_id is sampled with
// the first byte of each page. The registers (header_bytes,
// metadata_type_code) are taken into the page record with the last byte.
module page_header_validator_top
    import phv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Byte input
    input  logic        push,
    output logic        full,
    input  in_item_t    page_byte,
    // Result output
    output logic        empty,
    input  logic        pop,
    output out_item_t   result,
    // Configuration
    input  logic        wr_en,
    input  logic        reg_index,
    input  logic [15:0] wr_data
);

    logic [15:0] header_bytes_reg;
    logic [2:0]  meta_code_reg;

    logic      rec_push, rec_full, rec_pop, rec_empty;
    page_rec_t rec_in, rec_out;

    // Hold configuration; a write lands at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg <= 16'd64;
            meta_code_reg    <= 3'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_HEADER_BYTES: header_bytes_reg <= wr_data;
                REG_META_TYPE:    meta_code_reg    <= wr_data[2:0];
                default:          ;
            endcase
        end
    end

    // Accept bytes, advance CRC, capture header fields
    phv_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .page_byte    (page_byte),
        .header_bytes (header_bytes_reg),
        .meta_code    (meta_code_reg),
        .rec_push     (rec_push),
        .rec_full     (rec_full),
        .rec_data     (rec_in)
    );

    // Decouple the byte stream from the checker
    phv_rec_queue u_rec_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rec_push),
        .rec_in  (rec_in),
        .full    (rec_full),
        .pop     (rec_pop),
        .rec_out (rec_out),
        .empty   (rec_empty)
    );

    // Check one page record and queue its result
    phv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_empty (rec_empty),
        .rec_pop   (rec_pop),
        .rec_data  (rec_out),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

[verif/page_header_validator_top_test.sv]
// Self-checking testbench for page_header_validator_top: streams whole pages one
// byte per item, predicts each page verdict and compares it with every popped result.
// Depends on phv_pkg and the page_header_validator_top RTL.
module page_header_validator_top_test;
    import phv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits. The slowest phase idles the sender about 71 percent of the time,
    // which slows each page there; the limit leaves a wide margin.
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int READER_HOLD   = 30_000;
    localparam int RANDOM_PAGES  = 12;

    // Ways a generated page departs from a well-formed one. The faults from
    // TW_CSUM to TW_TIGHT are contiguous so that one can be drawn at random.
    typedef enum int {
        TW_NONE,
        TW_NOISE,
        TW_RAW_SEALED,
        TW_CSUM,
        TW_BODY,
        TW_MAGIC,
        TW_VERSION,
        TW_ID,
        TW_TYPE,
        TW_FLAGS,
        TW_META,
        TW_RESV,
        TW_LOWER,
        TW_ORDER,
        TW_UPPER_OVER,
        TW_UPPER_EDGE,
        TW_TIGHT
    } page_tweak_e;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    in_item_t    page_byte = '0;
    logic        empty;
    logic        pop       = 1'b0;
    out_item_t   result;
    logic        wr_en     = 1'b0;
    logic        reg_index = 1'b0;
    logic [15:0] wr_data   = '0;

    page_header_validator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .page_byte (page_byte),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .wr_en     (wr_en),
        .reg_index (reg_index),
        .wr_data   (wr_data)
    );

    // Traffic shaping, shared between the test sequence and the reader.
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int reader_hold_req = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    // Page image under construction, sent byte by byte.
    logic [7:0] page_buf [PAGE_BYTES];

    // Verdicts of finished pages that the block still owes, oldest first.
    out_item_t page_verdicts_due [$];

    // Own copy of the registers, updated at the write edge.
    logic [15:0] cfg_hdr_bytes = 16'd64;
    logic [2:0]  cfg_meta_code = 3'd1;

    // Per-page state of the verdict predictor.
    int          pos_r;
    logic [31:0] crc_acc;
    logic [31:0] csum_rx;
    logic [63:0] id_want;
    logic [31:0] magic_rx;
    logic [15:0] ver_rx;
    logic [15:0] type_rx;
    logic [63:0] id_rx;
    logic [15:0] slots_rx;
    logic [15:0] lo_rx;
    logic [15:0] hi_rx;
    logic [15:0] flags_rx;
    logic        resv_seen;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reflected CRC-32, one data bit at a time, least significant bit first.
    function automatic logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_id();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (v == 64'd0)
            v = 64'd1;
        return v;
    endfunction

    function automatic void restart_page();
        pos_r     = 0;
        crc_acc   = CRC_ONES;
        csum_rx   = '0;
        id_want   = '0;
        magic_rx  = '0;
        ver_rx    = '0;
        type_rx   = '0;
        id_rx     = '0;
        slots_rx  = '0;
        lo_rx     = '0;
        hi_rx     = '0;
        flags_rx  = '0;
        resv_seen = 1'b0;
    endfunction

    // Fold one accepted byte into the page state; on the last byte of a page
    // queue the verdict the block has to give and start the next page.
    function automatic void absorb_page_byte(in_item_t it);
        logic [7:0]  b;
        logic [31:0] crc_fin;
        logic [2:0]  st;
        int unsigned want_lower;
        out_item_t   verdict;
        b = it.data_byte;
        if (pos_r == 0)
            id_want = it.expected_page_id;
        // The checksum field is kept aside and counts as zero in the CRC.
        if (pos_r >= OFS_CSUM && pos_r <= OFS_CSUM_END) begin
            csum_rx[8*(pos_r-OFS_CSUM) +: 8] = b;
            crc_acc = crc_step(crc_acc, 8'h00);
        end
        else begin
            crc_acc = crc_step(crc_acc, b);
        end
        if (pos_r < OFS_VERSION)
            magic_rx[8*pos_r +: 8] = b;
        else if (pos_r < OFS_TYPE)
            ver_rx[8*(pos_r-OFS_VERSION) +: 8] = b;
        else if (pos_r < OFS_ID)
            type_rx[8*(pos_r-OFS_TYPE) +: 8] = b;
        else if (pos_r <= OFS_ID_END)
            id_rx[8*(pos_r-OFS_ID) +: 8] = b;
        else if (pos_r == OFS_SLOTS || pos_r == OFS_SLOTS + 1)
            slots_rx[8*(pos_r-OFS_SLOTS) +: 8] = b;
        else if (pos_r == OFS_LOWER || pos_r == OFS_LOWER + 1)
            lo_rx[8*(pos_r-OFS_LOWER) +: 8] = b;
        else if (pos_r == OFS_UPPER || pos_r == OFS_UPPER + 1)
            hi_rx[8*(pos_r-OFS_UPPER) +: 8] = b;
        else if (pos_r == OFS_FLAGS || pos_r == OFS_FLAGS + 1)
            flags_rx[8*(pos_r-OFS_FLAGS) +: 8] = b;
        else if (pos_r >= OFS_RESV && pos_r <= OFS_RESV_END && b != 8'h00)
            resv_seen = 1'b1;

        if (pos_r + 1 < PAGE_BYTES) begin
            pos_r++;
            return;
        end

        crc_fin = ~crc_acc;
        // Lower bound sum at full width: it must never wrap.
        want_lower = 32'(cfg_hdr_bytes) + 32'(slots_rx) * 4;
        if (crc_fin != csum_rx)
            st = ST_CRC;
        else if (magic_rx != PAGE_MAGIC || ver_rx != PAGE_VERSION || id_rx != id_want)
            st = ST_IDENT;
        else if (type_rx < TYPE_MIN || type_rx > TYPE_MAX || flags_rx != 16'd0)
            st = ST_TYPE;
        else if ((id_rx == 64'd0) != (type_rx == 16'(cfg_meta_code)))
            st = ST_META;
        else if (resv_seen)
            st = ST_RESV;
        else if (32'(lo_rx) != want_lower || lo_rx > hi_rx || 32'(hi_rx) > PAGE_BYTES)
            st = ST_BOUNDS;
        else
            st = ST_OK;
        verdict.status       = st;
        verdict.computed_crc = crc_fin;
        verdict.page_type    = type_rx;
        verdict.page_id      = id_rx;
        page_verdicts_due.push_back(verdict);
        restart_page();
    endfunction

    // Fill page_buf with a page of the given type, id and slot count, then
    // apply one tweak. want_id returns the id to present with the first byte.
    task automatic build_page(input logic [63:0] id, input logic [15:0] ptype,
                              input logic [15:0] slots, input page_tweak_e tweak,
                              output logic [63:0] want_id);
        logic [15:0] lower;
        logic [15:0] upper;
        logic [63:0] new_id;
        logic [31:0] acc;
        for (int p = 0; p < PAGE_BYTES; p++)
            page_buf[p] = 8'($urandom);
        want_id = {$urandom, $urandom};
        if (tweak != TW_NOISE && tweak != TW_RAW_SEALED) begin
            {page_buf[3], page_buf[2], page_buf[1], page_buf[0]} = PAGE_MAGIC;
            {page_buf[OFS_VERSION+1], page_buf[OFS_VERSION]} = PAGE_VERSION;
            {page_buf[OFS_TYPE+1], page_buf[OFS_TYPE]} = ptype;
            for (int k = 0; k < 8; k++)
                page_buf[OFS_ID+k] = id[8*k +: 8];
            want_id = id;
            // Store the bound the way a writer would: 16 bits, wrapping.
            lower = cfg_hdr_bytes + (slots << 2);
            if (lower <= PAGE_BYTES)
                upper = lower + 16'($urandom_range(PAGE_BYTES - lower));
            else
                upper = lower;
            {page_buf[OFS_FLAGS+1], page_buf[OFS_FLAGS]} = 16'd0;
            for (int p = OFS_RESV; p <= OFS_RESV_END; p++)
                page_buf[p] = 8'h00;
            case (tweak)
                TW_MAGIC:
                    page_buf[$urandom_range(3)] ^= 8'($urandom_range(255, 1));
                TW_VERSION:
                    {page_buf[OFS_VERSION+1], page_buf[OFS_VERSION]} =
                        ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(65535, 2));
                TW_ID:
                    want_id = id ^ (64'd1 << $urandom_range(63));
                TW_TYPE:
                    {page_buf[OFS_TYPE+1], page_buf[OFS_TYPE]} =
                        ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(65535, 5));
                TW_FLAGS:
                    {page_buf[OFS_FLAGS+1], page_buf[OFS_FLAGS]} = 16'd1 << $urandom_range(15);
                TW_META: begin
                    // Break the link between id zero and the metadata type.
                    new_id = (id == 64'd0) ? rand_id() : 64'd0;
                    for (int k = 0; k < 8; k++)
                        page_buf[OFS_ID+k] = new_id[8*k +: 8];
                    want_id = new_id;
                end
                TW_RESV:
                    page_buf[OFS_RESV + $urandom_range(19)] = 8'($urandom_range(255, 1));
                TW_LOWER:
                    lower ^= 16'd1 << $urandom_range(15);
                TW_ORDER:
                    upper = lower - 16'd1;
                TW_UPPER_OVER:
                    upper = 16'(PAGE_BYTES + 1);
                TW_UPPER_EDGE:
                    upper = 16'(PAGE_BYTES);
                TW_TIGHT:
                    upper = lower;
                default: ;
            endcase
            {page_buf[OFS_SLOTS+1], page_buf[OFS_SLOTS]} = slots;
            {page_buf[OFS_LOWER+1], page_buf[OFS_LOWER]} = lower;
            {page_buf[OFS_UPPER+1], page_buf[OFS_UPPER]} = upper;
        end
        if (tweak == TW_RAW_SEALED) begin
            for (int k = 0; k < 8; k++)
                want_id[8*k +: 8] = page_buf[OFS_ID+k];
        end
        // Seal: CRC with the checksum field zeroed, stored little-endian.
        if (tweak != TW_NOISE) begin
            for (int k = 0; k < 4; k++)
                page_buf[OFS_CSUM+k] = 8'h00;
            acc = CRC_ONES;
            for (int p = 0; p < PAGE_BYTES; p++)
                acc = crc_step(acc, page_buf[p]);
            acc = ~acc;
            for (int k = 0; k < 4; k++)
                page_buf[OFS_CSUM+k] = acc[8*k +: 8];
        end
        if (tweak == TW_CSUM)
            page_buf[OFS_CSUM + $urandom_range(3)] ^= 8'($urandom_range(255, 1));
        else if (tweak == TW_BODY)
            page_buf[$urandom_range(PAGE_BYTES - 1, OFS_RESV_END + 1)] ^=
                8'($urandom_range(255, 1));
    endtask

    // Offer one item, idling first at random; return on the accepting edge.
    task automatic send_byte(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        page_byte <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        absorb_page_byte(it);
    endtask

    // Stream page_buf; the expected id rides only on the first byte, so give
    // the others random ids to show they are ignored.
    task automatic send_page(input logic [63:0] want_id);
        in_item_t it;
        for (int p = 0; p < PAGE_BYTES; p++) begin
            it.data_byte        = page_buf[p];
            it.expected_page_id = (p == 0) ? want_id : {$urandom, $urandom};
            send_byte(it);
        end
    endtask

    task automatic make_and_send(input logic [63:0] id, input logic [15:0] ptype,
                                 input logic [15:0] slots, input page_tweak_e tweak);
        logic [63:0] want_id;
        build_page(id, ptype, slots, tweak, want_id);
        send_page(want_id);
    endtask

    // Drop push, wait for every owed verdict, then let the pipeline settle.
    task automatic wait_idle();
        push <= 1'b0;
        while (page_verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write both registers on consecutive edges. Only called while idle.
    task automatic set_registers(input logic [15:0] hdr, input logic [2:0] code);
        wr_en     <= 1'b1;
        reg_index <= REG_HEADER_BYTES;
        wr_data   <= hdr;
        @(posedge clk);
        cfg_hdr_bytes = hdr;
        // Upper data bits are junk for the 3-bit register.
        reg_index <= REG_META_TYPE;
        wr_data   <= {13'($urandom), code};
        @(posedge clk);
        cfg_meta_code = code;
        wr_en <= 1'b0;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (page_verdicts_due.size() == 0) begin
            $display("%0t: unexpected result: status %0d crc %h type %h id %h", $time,
                     got.status, got.computed_crc, got.page_type, got.page_id);
            mismatch_count++;
            return;
        end
        want = page_verdicts_due.pop_front();
        if (got.status != want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            mismatch_count++;
        end
        if (got.computed_crc != want.computed_crc) begin
            $display("%0t: computed_crc mismatch: expected %h, actual %h",
                     $time, want.computed_crc, got.computed_crc);
            mismatch_count++;
        end
        if (got.page_type != want.page_type) begin
            $display("%0t: page_type mismatch: expected %h, actual %h",
                     $time, want.page_type, got.page_type);
            mismatch_count++;
        end
        if (got.page_id != want.page_id) begin
            $display("%0t: page_id mismatch: expected %h, actual %h",
                     $time, want.page_id, got.page_id);
            mismatch_count++;
        end
    endtask

    // Reader: take a result at each edge where pop and not empty, then pick
    // the next pop. A hold request freezes pop for a counted stretch.
    initial begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (pop && !empty)
                check_result(result);
            if (reader_hold_req > 0) begin
                hold_left       = reader_hold_req;
                reader_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run if it has not finished well past the slowest pace.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Registers at their reset values: good data page, metadata page, all-ones id.
    task automatic test_reset_defaults();
        make_and_send(rand_id(), 16'd2, 16'd3, TW_NONE);
        make_and_send(64'd0, 16'd1, 16'd0, TW_NONE);
        make_and_send({64{1'b1}}, 16'd3, 16'd7, TW_NONE);
    endtask

    // Checksum and identity failures.
    task automatic test_integrity_checks();
        make_and_send(rand_id(), 16'd2, 16'd4, TW_CSUM);
        make_and_send(rand_id(), 16'd2, 16'd4, TW_BODY);
        make_and_send(rand_id(), 16'd3, 16'd4, TW_MAGIC);
        make_and_send(rand_id(), 16'd3, 16'd4, TW_VERSION);
        make_and_send(rand_id(), 16'd4, 16'd4, TW_ID);
    endtask

    // Type range, flags, metadata location and reserved bytes.
    task automatic test_type_and_meta();
        make_and_send(rand_id(), 16'd0, 16'd2, TW_NONE);
        make_and_send(rand_id(), 16'hffff, 16'd2, TW_NONE);
        make_and_send(rand_id(), 16'd2, 16'd2, TW_FLAGS);
        make_and_send(64'd0, 16'd1, 16'd2, TW_META);
        make_and_send(64'd0, 16'd2, 16'd2, TW_NONE);
        make_and_send(rand_id(), 16'd4, 16'd2, TW_RESV);
    endtask

    // Slot directory bounds, including the edges that still pass.
    task automatic test_slot_bounds();
        make_and_send(rand_id(), 16'd2, 16'd9, TW_LOWER);
        make_and_send(rand_id(), 16'd2, 16'd9, TW_ORDER);
        make_and_send(rand_id(), 16'd2, 16'd9, TW_UPPER_OVER);
        make_and_send(rand_id(), 16'd2, 16'd9, TW_UPPER_EDGE);
        make_and_send(rand_id(), 16'd2, 16'd9, TW_TIGHT);
    endtask

    // Register extremes: zero header, a lower-bound sum that would wrap in 16
    // bits, and metadata codes outside the valid type range.
    task automatic test_register_extremes();
        wait_idle();
        set_registers(16'd0, 3'd4);
        make_and_send(64'd0, 16'd4, 16'd0, TW_TIGHT);
        wait_idle();
        set_registers(16'hfffc, 3'd0);
        make_and_send(rand_id(), 16'd1, 16'd1, TW_NONE);
        make_and_send(64'd0, 16'd3, 16'd1, TW_NONE);
        wait_idle();
        set_registers(16'hffff, 3'd7);
        make_and_send(rand_id(), 16'd2, 16'd0, TW_NONE);
        make_and_send(64'd0, 16'd4, 16'd0, TW_NONE);
    endtask

    // Random pages: well formed, with one fault, noise, or sealed random data.
    // Registers are rewritten now and then between pages.
    task automatic test_random_pages(input int n_pages, input int sender_pct,
                                     input int reader_pct);
        int          r;
        page_tweak_e tweak;
        logic [15:0] ptype;
        logic [63:0] id;
        logic [15:0] hdr;
        logic [2:0]  code;
        wait_idle();
        send_idle_pct = sender_pct;
        recv_idle_pct = reader_pct;
        for (int n = 0; n < n_pages; n++) begin
            if ($urandom_range(3) == 0) begin
                wait_idle();
                hdr  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(256));
                code = ($urandom_range(7) == 0) ? 3'($urandom) : 3'($urandom_range(4, 1));
                set_registers(hdr, code);
            end
            r = $urandom_range(99);
            if (r < 10)
                tweak = TW_NOISE;
            else if (r < 20)
                tweak = TW_RAW_SEALED;
            else if (r < 55)
                tweak = TW_NONE;
            else
                tweak = page_tweak_e'($urandom_range(TW_TIGHT, TW_CSUM));
            ptype = 16'($urandom_range(4, 1));
            id    = (ptype == 16'(cfg_meta_code)) ? 64'd0 : rand_id();
            make_and_send(id, ptype, 16'($urandom_range(200)), tweak);
        end
    endtask

    // Hold the reader off long enough that both internal queues fill and
    // full stalls the last byte of a page, then drain as the sender finishes.
    task automatic test_backpressure();
        wait_idle();
        send_idle_pct   = 0;
        reader_hold_req = READER_HOLD;
        for (int n = 0; n < 6; n++)
            make_and_send(rand_id(), 16'(2 + n % 3), 16'($urandom_range(50)), TW_NONE);
        wait_idle();
    endtask

    initial begin
        restart_page();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 15;
        recv_idle_pct = 71;
        test_reset_defaults();
        test_integrity_checks();
        test_type_and_meta();
        test_slot_bounds();
        test_register_extremes();
        test_random_pages(RANDOM_PAGES, 15, 71);
        test_random_pages(RANDOM_PAGES, 71, 15);
        test_random_pages(RANDOM_PAGES, 0, 0);
        test_backpressure();
        wait_idle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/phv_pkg.sv
rtl/phv_front.sv
rtl/phv_rec_queue.sv
rtl/phv_back.sv
rtl/page_header_validator_top.sv
verif/page_header_validator_top_test.sv
